// ===== hw/rtl/u8cpml_pkg.sv =====
// u8cpml_pkg: widths, stop reason codes and lead byte decode for the
// utf8 whole code point match length block
// no dependencies
package u8cpml_pkg;

  localparam int BYTE_W              = 8;
  localparam int LIMIT_W             = 16;
  localparam int MATCH_W             = 16;
  localparam int REASON_W            = 2;
  localparam int CPLEN_W             = 3;
  localparam int LEFT_W              = 2;
  localparam int COUNT_WIDTH_DEFAULT = 16;

  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 16'hffff;

  localparam logic [REASON_W-1:0] REASON_MISMATCH   = 2'd0;
  localparam logic [REASON_W-1:0] REASON_INVALID    = 2'd1;
  localparam logic [REASON_W-1:0] REASON_LIMIT      = 2'd2;
  localparam logic [REASON_W-1:0] REASON_DATA_ENDED = 2'd3;

  localparam logic [BYTE_W-1:0] MASK_1B = 8'h80;
  localparam logic [BYTE_W-1:0] MASK_2B = 8'he0;
  localparam logic [BYTE_W-1:0] LEAD_2B = 8'hc0;
  localparam logic [BYTE_W-1:0] MASK_3B = 8'hf0;
  localparam logic [BYTE_W-1:0] LEAD_3B = 8'he0;
  localparam logic [BYTE_W-1:0] MASK_4B = 8'hf8;
  localparam logic [BYTE_W-1:0] LEAD_4B = 8'hf0;

  // code point length from its lead byte, zero when invalid
  function automatic logic [CPLEN_W-1:0] lead_length(input logic [BYTE_W-1:0] lead);
    logic [CPLEN_W-1:0] len;
    if ((lead & MASK_1B) == '0) begin
      len = 3'd1;
    end else if ((lead & MASK_2B) == LEAD_2B) begin
      len = 3'd2;
    end else if ((lead & MASK_3B) == LEAD_3B) begin
      len = 3'd3;
    end else if ((lead & MASK_4B) == LEAD_4B) begin
      len = 3'd4;
    end else begin
      len = 3'd0;
    end
    return len;
  endfunction

endpackage

// ===== hw/rtl/u8cpml_if.sv =====
// u8cpml_in_if and u8cpml_out_if: valid/ready channels for byte pairs
// and match results
// depends on u8cpml_pkg
interface u8cpml_in_if;
  logic                             valid;
  logic                             ready;
  logic [u8cpml_pkg::BYTE_W-1:0]    byte_a;
  logic [u8cpml_pkg::BYTE_W-1:0]    byte_b;
  logic                             first;
  logic                             last;

  modport source (output valid, output byte_a, output byte_b, output first, output last,
                  input ready);
  modport sink   (input valid, input byte_a, input byte_b, input first, input last,
                  output ready);
endinterface

interface u8cpml_out_if;
  logic                             valid;
  logic                             ready;
  logic [u8cpml_pkg::MATCH_W-1:0]   match_bytes;
  logic [u8cpml_pkg::REASON_W-1:0]  stop_reason;

  modport source (output valid, output match_bytes, output stop_reason, input ready);
  modport sink   (input valid, input match_bytes, input stop_reason, output ready);
endinterface

// ===== hw/rtl/utf8_whole_codepoint_match_length.sv =====
// utf8_whole_codepoint_match_length: counts bytes matched in whole utf-8
// code points between two streams, up to a configured limit
// depends on u8cpml_pkg, u8cpml_in_if, u8cpml_out_if
//
//   channel   dir   payload                      handshake
//   pairs     in    byte_a, byte_b, first, last  valid/ready
//   result    out   match_bytes, stop_reason     valid/ready
//   limit     in    limit_data                   limit_we
//
// one item per cycle sustained while the result is not stalled; an accepted item
// passes through the input register and then the result register
// reset clears the comparison state and sets the limit to 65535
// a stalled result holds the item in the input register; ready drops only
// in reset or while both registers are full
module utf8_whole_codepoint_match_length #(
  parameter int COUNT_WIDTH = u8cpml_pkg::COUNT_WIDTH_DEFAULT
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           limit_we,
  input  logic [u8cpml_pkg::LIMIT_W-1:0] limit_data,
  u8cpml_in_if.sink                      pairs,
  u8cpml_out_if.source                   result
);
  import u8cpml_pkg::*;

  localparam int SUM_W = ((COUNT_WIDTH > LIMIT_W) ? COUNT_WIDTH : LIMIT_W) + 1;
  localparam logic [SUM_W-1:0] CAP = SUM_W'({COUNT_WIDTH{1'b1}});

  logic [LIMIT_W-1:0]     match_limit;
  logic                   active;
  logic [COUNT_WIDTH-1:0] committed_count;
  logic [CPLEN_W-1:0]     codepoint_length;
  logic [LEFT_W-1:0]      bytes_left;

  logic                   pair_valid;
  logic [BYTE_W-1:0]      pair_a;
  logic [BYTE_W-1:0]      pair_b;
  logic                   pair_first;
  logic                   pair_last;

  logic                   out_valid;
  logic [MATCH_W-1:0]     out_match;
  logic [REASON_W-1:0]    out_reason;

  logic                   advance;
  logic                   run;
  logic [SUM_W-1:0]       lim;
  logic [SUM_W-1:0]       cnt;
  logic [CPLEN_W-1:0]     cplen;
  logic [LEFT_W-1:0]      left;
  logic [CPLEN_W-1:0]     lead_len;

  logic                   done;
  logic [REASON_W-1:0]    reason;
  logic [SUM_W-1:0]       count_next;
  logic [CPLEN_W-1:0]     codepoint_length_next;
  logic [LEFT_W-1:0]      bytes_left_next;

  assign advance      = pair_valid && (!out_valid || result.ready);
  assign pairs.ready  = !rst && (!pair_valid || advance);

  assign result.valid       = out_valid;
  assign result.match_bytes = out_match;
  assign result.stop_reason = out_reason;

  // limit in force is capped by the count width
  assign lim      = (SUM_W'(match_limit) < CAP) ? SUM_W'(match_limit) : CAP;
  assign run      = pair_first || active;
  assign cnt      = pair_first ? '0 : SUM_W'(committed_count);
  assign cplen    = pair_first ? '0 : codepoint_length;
  assign left     = pair_first ? '0 : bytes_left;
  assign lead_len = lead_length(pair_a);

  always_comb begin
    done                  = 1'b0;
    reason                = REASON_MISMATCH;
    count_next            = cnt;
    codepoint_length_next = cplen;
    bytes_left_next       = left;
    if (left == '0) begin
      if (lead_len == '0) begin
        done   = 1'b1;
        reason = REASON_INVALID;
      end else if (cnt + SUM_W'(lead_len) > lim) begin
        done   = 1'b1;
        reason = REASON_LIMIT;
      end else if (pair_a != pair_b) begin
        done   = 1'b1;
        reason = REASON_MISMATCH;
      end else begin
        codepoint_length_next = lead_len;
        bytes_left_next       = LEFT_W'(lead_len - 3'd1);
      end
    end else if (pair_a != pair_b) begin
      done   = 1'b1;
      reason = REASON_MISMATCH;
    end else begin
      bytes_left_next = left - 2'd1;
    end
    if (!done && bytes_left_next == '0) begin
      count_next = cnt + SUM_W'(codepoint_length_next);
      if (count_next >= lim) begin
        done   = 1'b1;
        reason = REASON_LIMIT;
      end
    end
    if (!done && pair_last) begin
      done   = 1'b1;
      reason = REASON_DATA_ENDED;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      match_limit      <= LIMIT_RESET;
      active           <= 1'b0;
      committed_count  <= '0;
      codepoint_length <= '0;
      bytes_left       <= '0;
      pair_valid       <= 1'b0;
      out_valid        <= 1'b0;
    end else begin
      if (limit_we) begin
        match_limit <= limit_data;
      end
      if (pairs.valid && pairs.ready) begin
        pair_valid <= 1'b1;
      end else if (advance) begin
        pair_valid <= 1'b0;
      end
      if (advance) begin
        out_valid <= run && done;
        if (run) begin
          active           <= !done;
          committed_count  <= COUNT_WIDTH'(count_next);
          codepoint_length <= done ? '0 : codepoint_length_next;
          bytes_left       <= done ? '0 : bytes_left_next;
        end
      end else if (result.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (pairs.valid && pairs.ready) begin
      pair_a     <= pairs.byte_a;
      pair_b     <= pairs.byte_b;
      pair_first <= pairs.first;
      pair_last  <= pairs.last;
    end
    if (advance) begin
      out_match  <= MATCH_W'(count_next);
      out_reason <= reason;
    end
  end

endmodule

// ===== hw/rtl/u8cpml_checker.sv =====
// u8cpml_checker: port level assertions for the match length block,
// bound to utf8_whole_codepoint_match_length
// depends on u8cpml_pkg
module u8cpml_checker (
  input logic                           clk,
  input logic                           rst,
  input logic                           in_valid,
  input logic                           in_ready,
  input logic                           out_valid,
  input logic                           out_ready,
  input logic [u8cpml_pkg::MATCH_W-1:0] match_bytes,
  input logic [u8cpml_pkg::REASON_W-1:0] stop_reason
);

  // result payload is known while valid
  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !$isunknown({match_bytes, stop_reason}))
    else $error("unknown result payload");

  // a fresh result needs an earlier accepted item, checked across the input and result registers
  assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(in_valid && in_ready, 2))
    else $error("result without an accepted item");

  // stalled result holds
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(match_bytes) && $stable(stop_reason))
    else $error("stalled result changed");

  // no result right after reset
  assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind utf8_whole_codepoint_match_length u8cpml_checker u_chk (
  .clk         (clk),
  .rst         (rst),
  .in_valid    (pairs.valid),
  .in_ready    (pairs.ready),
  .out_valid   (result.valid),
  .out_ready   (result.ready),
  .match_bytes (result.match_bytes),
  .stop_reason (result.stop_reason)
);

// ===== test/utf8_whole_codepoint_match_length_tb.sv =====
// utf8_whole_codepoint_match_length_tb: self-checking bench that streams byte pairs
// under several match limits and checks each count and stop reason against a predictor
// depends on u8cpml_pkg, u8cpml_in_if, u8cpml_out_if and the utf8_whole_codepoint_match_length rtl
module utf8_whole_codepoint_match_length_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import u8cpml_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int MAX_REPORTS = 10;
  localparam int RUN_ITEMS   = 60;
  localparam int NUM_PHASES  = 8;

  typedef struct packed {
    logic [BYTE_W-1:0] a;
    logic [BYTE_W-1:0] b;
    logic              first;
    logic              last;
  } byte_pair_t;

  typedef struct packed {
    logic [MATCH_W-1:0]  count;
    logic [REASON_W-1:0] reason;
  } match_result_t;

  logic               clk = 1'b0;
  logic               rst;
  logic               limit_we;
  logic [LIMIT_W-1:0] limit_data;
  logic               in_taken;

  u8cpml_in_if  pairs_if();
  u8cpml_out_if result_if();

  utf8_whole_codepoint_match_length u_dut (
    .clk        (clk),
    .rst        (rst),
    .limit_we   (limit_we),
    .limit_data (limit_data),
    .pairs      (pairs_if),
    .result     (result_if)
  );

  byte_pair_t    byte_pairs_todo[$];
  match_result_t pending_results[$];

  int idle_pct = 32;
  int cycle_count = 0;
  int pairs_accepted = 0;
  int results_checked = 0;
  int error_count = 0;
  int limits_written = 0;

  // predictor state
  int unsigned model_limit = 32'(LIMIT_RESET);
  bit          cmp_active = 1'b0;
  int          cmp_count = 0;
  int          cp_len = 0;
  int          cp_left = 0;

  always #1 clk = ~clk;

  function automatic int utf8_seq_len(input logic [BYTE_W-1:0] lead);
    int n;
    casez (lead)
      8'b0???????: n = 1;
      8'b110?????: n = 2;
      8'b1110????: n = 3;
      8'b11110???: n = 4;
      default:     n = 0;
    endcase
    return n;
  endfunction

  task automatic predict_match(input byte_pair_t p);
    int                  len;
    bit                  done;
    logic [REASON_W-1:0] why;
    done = 1'b0;
    why = REASON_MISMATCH;
    if (p.first) begin
      cmp_active = 1'b1;
      cmp_count = 0;
      cp_len = 0;
      cp_left = 0;
    end
    if (!cmp_active) begin
      return;
    end
    if (cp_left == 0) begin
      len = utf8_seq_len(p.a);
      if (len == 0) begin
        done = 1'b1;
        why = REASON_INVALID;
      end else if (cmp_count + len > model_limit) begin
        done = 1'b1;
        why = REASON_LIMIT;
      end else if (p.a != p.b) begin
        done = 1'b1;
        why = REASON_MISMATCH;
      end else begin
        cp_len = len;
        cp_left = len - 1;
      end
    end else if (p.a != p.b) begin
      done = 1'b1;
      why = REASON_MISMATCH;
    end else begin
      cp_left = cp_left - 1;
    end
    if (!done && cp_left == 0) begin
      cmp_count = cmp_count + cp_len;
      if (cmp_count >= model_limit) begin
        done = 1'b1;
        why = REASON_LIMIT;
      end
    end
    if (!done && p.last) begin
      done = 1'b1;
      why = REASON_DATA_ENDED;
    end
    if (done) begin
      pending_results.push_back('{count: MATCH_W'(cmp_count), reason: why});
      cmp_active = 1'b0;
      cp_len = 0;
      cp_left = 0;
    end
  endtask

  // input side: sample handshake, predict, check results
  always @(posedge clk) begin
    match_result_t got;
    match_result_t want;
    cycle_count <= cycle_count + 1;
    if (rst) begin
      in_taken <= 1'b0;
    end else begin
      in_taken <= pairs_if.valid && pairs_if.ready;
      if (pairs_if.valid && pairs_if.ready) begin
        predict_match('{a: pairs_if.byte_a, b: pairs_if.byte_b,
                        first: pairs_if.first, last: pairs_if.last});
        pairs_accepted++;
      end
      if (result_if.valid && result_if.ready) begin
        got = '{count: result_if.match_bytes, reason: result_if.stop_reason};
        results_checked++;
        if (pending_results.size() == 0) begin
          if (error_count < MAX_REPORTS) begin
            $display("unexpected result: count %0d reason %0d", got.count, got.reason);
          end
          error_count++;
        end else begin
          want = pending_results.pop_front();
          if (want != got) begin
            if (error_count < MAX_REPORTS) begin
              $display("result %0d mismatch: expected count %0d reason %0d, got count %0d reason %0d",
                       results_checked, want.count, want.reason, got.count, got.reason);
            end
            error_count++;
          end
        end
      end
    end
  end

  // driver and result back-pressure, changed on the falling edge
  always @(negedge clk) begin
    byte_pair_t nxt;
    if (!rst) begin
      if (!pairs_if.valid || in_taken) begin
        if (byte_pairs_todo.size() > 0 && $urandom_range(99) >= idle_pct) begin
          nxt = byte_pairs_todo.pop_front();
          pairs_if.valid  <= 1'b1;
          pairs_if.byte_a <= nxt.a;
          pairs_if.byte_b <= nxt.b;
          pairs_if.first  <= nxt.first;
          pairs_if.last   <= nxt.last;
        end else begin
          pairs_if.valid <= 1'b0;
        end
      end
      result_if.ready <= ($urandom_range(99) >= idle_pct);
    end
  end

  always @(posedge clk) begin
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("utf8_whole_codepoint_match_length regression: fail");
      $finish;
    end
  end

  task automatic add_pair(input logic [7:0] a, input logic [7:0] b, input bit first,
                          input bit last);
    byte_pairs_todo.push_back('{a: a, b: b, first: first, last: last});
  endtask

  // len 0 gives one invalid lead byte; keep cuts the code point short
  task automatic queue_codepoint(input int len, input bit start, input int keep,
                                 input bit stop, input int bad);
    logic [7:0] a;
    logic [7:0] b;
    for (int k = 0; k < keep; k++) begin
      if (k == 0) begin
        case (len)
          1:       a = {1'b0, 7'($urandom)};
          2:       a = {3'b110, 5'($urandom)};
          3:       a = {4'b1110, 4'($urandom)};
          4:       a = {5'b11110, 3'($urandom)};
          default: a = $urandom_range(1) ? {2'b10, 6'($urandom)} : {5'b11111, 3'($urandom)};
        endcase
      end else if ($urandom_range(9) == 0) begin
        a = 8'($urandom);
      end else begin
        a = {2'b10, 6'($urandom)};
      end
      b = (k == bad) ? a ^ 8'($urandom_range(1, 255)) : a;
      add_pair(a, b, start && k == 0, stop && k == keep - 1);
    end
  endtask

  task automatic queue_random_run(inout int budget);
    int queued_start;
    int ncp;
    int ending;
    int bad_cp;
    int len;
    int nb;
    int keep;
    bit fin;
    queued_start = byte_pairs_todo.size();
    if ($urandom_range(19) == 0) begin
      add_pair(8'($urandom), 8'($urandom), 1'($urandom), 1'($urandom));
    end else begin
      ncp = $urandom_range(1, 8);
      ending = $urandom_range(99);
      bad_cp = $urandom_range(0, ncp - 1);
      for (int i = 0; i < ncp; i++) begin
        fin = (i == ncp - 1);
        len = (fin && ending >= 70 && ending < 80) ? 0 : $urandom_range(1, 4);
        nb = (len == 0) ? 1 : len;
        keep = (fin && ending >= 80 && ending < 90 && nb > 1) ? $urandom_range(1, nb - 1) : nb;
        queue_codepoint(len, i == 0, keep, fin && ending < 90,
                        (ending >= 55 && ending < 70 && i == bad_cp) ?
                        $urandom_range(0, nb - 1) : -1);
      end
    end
    budget -= byte_pairs_todo.size() - queued_start;
    if ($urandom_range(99) < 15) begin
      repeat ($urandom_range(1, 3)) begin
        add_pair(8'($urandom), 8'($urandom), 1'b0, 1'($urandom));
      end
    end
  endtask

  // wait until every item is in and every result out, then let the pipeline empty
  task automatic drain();
    do begin
      @(negedge clk);
    end while (byte_pairs_todo.size() != 0 || pairs_if.valid || pending_results.size() != 0);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_limit(input logic [LIMIT_W-1:0] value);
    drain();
    limit_we   <= 1'b1;
    limit_data <= value;
    @(negedge clk);
    limit_we <= 1'b0;
    model_limit = 32'(value);
    limits_written++;
  endtask

  initial begin
    logic [LIMIT_W-1:0] phase_limits[NUM_PHASES];
    int                 budget;
    rst = 1'b1;
    limit_we = 1'b0;
    limit_data = '0;
    pairs_if.valid = 1'b0;
    pairs_if.byte_a = '0;
    pairs_if.byte_b = '0;
    pairs_if.first = 1'b0;
    pairs_if.last = 1'b0;
    result_if.ready = 1'b0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    write_limit(LIMIT_RESET);
    add_pair(8'h41, 8'h41, 1'b1, 1'b1);
    add_pair(8'hc3, 8'hc3, 1'b1, 1'b0);
    add_pair(8'ha9, 8'ha9, 1'b0, 1'b0);
    add_pair(8'he2, 8'he2, 1'b0, 1'b0);
    add_pair(8'h82, 8'h82, 1'b0, 1'b0);
    add_pair(8'hac, 8'hac, 1'b0, 1'b0);
    add_pair(8'hf0, 8'hf0, 1'b0, 1'b0);
    add_pair(8'h9f, 8'h9f, 1'b0, 1'b0);
    add_pair(8'h98, 8'h98, 1'b0, 1'b0);
    add_pair(8'h80, 8'h80, 1'b0, 1'b1);
    add_pair(8'h80, 8'h80, 1'b1, 1'b0);
    add_pair(8'hff, 8'hff, 1'b1, 1'b1);
    add_pair(8'h00, 8'h00, 1'b1, 1'b0);
    add_pair(8'h7f, 8'hff, 1'b0, 1'b1);
    add_pair(8'hf0, 8'hf0, 1'b1, 1'b0);
    add_pair(8'h9f, 8'h9f, 1'b0, 1'b0);
    add_pair(8'h98, 8'h98, 1'b0, 1'b1);
    add_pair(8'h55, 8'haa, 1'b0, 1'b0);
    add_pair(8'h61, 8'h61, 1'b1, 1'b0);
    add_pair(8'h62, 8'h62, 1'b1, 1'b1);

    write_limit('0);
    add_pair(8'h41, 8'h41, 1'b1, 1'b1);
    write_limit(16'd3);
    add_pair(8'hc3, 8'hc3, 1'b1, 1'b0);
    add_pair(8'ha9, 8'ha9, 1'b0, 1'b0);
    add_pair(8'hc3, 8'hc3, 1'b0, 1'b0);
    write_limit(16'd2);
    add_pair(8'h41, 8'h41, 1'b1, 1'b0);
    add_pair(8'h42, 8'h42, 1'b0, 1'b1);

    phase_limits[0] = LIMIT_RESET;
    phase_limits[1] = '0;
    phase_limits[2] = 16'd1;
    phase_limits[3] = LIMIT_W'($urandom_range(0, 40));
    phase_limits[4] = 16'd7;
    phase_limits[5] = LIMIT_W'($urandom);
    phase_limits[6] = 16'd4;
    phase_limits[7] = LIMIT_W'($urandom_range(0, 40));
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      write_limit(phase_limits[ph]);
      idle_pct = (ph == 3) ? 0 : 32;
      budget = RUN_ITEMS;
      while (budget > 0) begin
        queue_random_run(budget);
      end
    end

    drain();
    repeat (10) @(negedge clk);
    $display("sent %0d byte pairs under %0d limit settings, checked %0d results",
             pairs_accepted, limits_written, results_checked);
    $display("%0d results still outstanding, %0d errors", pending_results.size(), error_count);
    if (error_count == 0 && pending_results.size() == 0) begin
      $display("utf8_whole_codepoint_match_length regression: pass");
    end else begin
      $display("utf8_whole_codepoint_match_length regression: fail");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
hw/rtl/u8cpml_pkg.sv
hw/rtl/u8cpml_if.sv
hw/rtl/utf8_whole_codepoint_match_length.sv
hw/rtl/u8cpml_checker.sv
test/utf8_whole_codepoint_match_length_tb.sv
